### rtl/atrp_pkg.sv
// types, codes and character constants shared by the response parser files
`timescale 1ns / 1ps

package atrp_pkg;

   // line buffer size, fixed by the widths of the store and count fields
   localparam int MAX_LINES    = 8;
   localparam int MAX_LINE_LEN = 128;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_R     = 8'h52;

   typedef enum logic [4:0] {
      ST_WAIT_CR    = 5'd0,
      ST_WAIT_LF    = 5'd1,
      ST_LINE_START = 5'd2,
      ST_OK_K       = 5'd3,
      ST_OK_CR      = 5'd4,
      ST_OK_LF      = 5'd5,
      ST_OK_DONE    = 5'd6,
      ST_ERR_R1     = 5'd7,
      ST_ERR_R2     = 5'd8,
      ST_ERR_O      = 5'd9,
      ST_ERR_R3     = 5'd10,
      ST_ERR_CR     = 5'd11,
      ST_ERR_LF     = 5'd12,
      ST_ERR_DONE   = 5'd13,
      ST_PLUS       = 5'd14,
      ST_DATA       = 5'd15,
      ST_DATA_LF    = 5'd16,
      ST_LINE_END   = 5'd17,
      ST_TAIL_LF    = 5'd18,
      ST_FINAL      = 5'd19
   } state_type;

   typedef enum logic [1:0] {
      STAT_NOT_READY = 2'd0,
      STAT_DONE      = 2'd1,
      STAT_ERROR     = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] status;
      logic       response_ok;
      logic [3:0] lines_held;
      logic       clear_record;
      logic       char_stored;
      logic [2:0] store_line;
      logic [6:0] store_column;
      logic [7:0] store_char;
      logic       line_closed;
      logic [7:0] closed_length;
   } result_type;

   function automatic logic is_print(input logic [7:0] c);
      return (c >= PRINT_LO) && (c <= PRINT_HI);
   endfunction

endpackage

### rtl/atrp_if.sv
// valid/ready channel interfaces for the byte input and the result output
`timescale 1ns / 1ps

interface atrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface atrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       response_ok;
   logic [3:0] lines_held;
   logic       clear_record;
   logic       char_stored;
   logic [2:0] store_line;
   logic [6:0] store_column;
   logic [7:0] store_char;
   logic       line_closed;
   logic [7:0] closed_length;

   modport source (output valid, input ready, output status, output response_ok,
                   output lines_held, output clear_record, output char_stored,
                   output store_line, output store_column, output store_char,
                   output line_closed, output closed_length);
   modport sink (input valid, output ready, input status, input response_ok,
                 input lines_held, input clear_record, input char_stored,
                 input store_line, input store_column, input store_char,
                 input line_closed, input closed_length);
endinterface

### rtl/atrp_core.sv
// recognizer state machine with column, line and ok tracking, one byte per step
`timescale 1ns / 1ps

module atrp_core
   import atrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] char_in,
   output result_type result
);

   localparam int LW = $clog2(MAX_LINES + 1);
   localparam int CW = $clog2(MAX_LINE_LEN + 1);

   state_type       state_ff, state_in;
   logic [CW-1:0]   column_ff, column_in;
   logic [LW-1:0]   lines_ff, lines_in;
   logic            ok_ff, ok_in;

   status_type      status;
   logic            clear_rec;
   logic            store_req;
   logic            close_req;
   logic            ok_load;
   logic            ok_val;
   logic            do_store;
   logic            do_close;

   // next state: any byte that does not match leaves the state as it is, but the done states move on with every byte
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WAIT_CR: begin
            state_in = (char_in == CHAR_CR) ? ST_WAIT_LF : ST_WAIT_CR;
         end
         ST_WAIT_LF: begin
            if (char_in == CHAR_LF) state_in = ST_LINE_START;
         end
         ST_LINE_START: begin
            if (char_in == CHAR_O) state_in = ST_OK_K;
            else if (char_in == CHAR_E) state_in = ST_ERR_R1;
            else if (char_in == CHAR_PLUS) state_in = ST_PLUS;
            else if (char_in != CHAR_C && is_print(char_in)) state_in = ST_DATA;
         end
         ST_OK_K: begin
            if (char_in == CHAR_K) state_in = ST_OK_CR;
         end
         ST_OK_CR: begin
            if (char_in == CHAR_CR) state_in = ST_OK_LF;
         end
         ST_OK_LF: begin
            if (char_in == CHAR_LF) state_in = ST_OK_DONE;
         end
         ST_ERR_CR: begin
            if (char_in == CHAR_CR) state_in = ST_ERR_LF;
         end
         ST_ERR_LF: begin
            if (char_in == CHAR_LF) state_in = ST_ERR_DONE;
         end
         ST_OK_DONE, ST_ERR_DONE: begin
            state_in = (char_in == CHAR_CR) ? ST_WAIT_LF : ST_WAIT_CR;
         end
         ST_ERR_R1: begin
            if (char_in == CHAR_R) state_in = ST_ERR_R2;
         end
         ST_ERR_R2: begin
            if (char_in == CHAR_R) state_in = ST_ERR_O;
         end
         ST_ERR_O: begin
            if (char_in == CHAR_O) state_in = ST_ERR_R3;
         end
         ST_ERR_R3: begin
            if (char_in == CHAR_R) state_in = ST_ERR_CR;
         end
         ST_PLUS: begin
            if (char_in == CHAR_C) state_in = ST_DATA;
         end
         ST_DATA: begin
            if (!is_print(char_in) && char_in == CHAR_CR) state_in = ST_DATA_LF;
         end
         ST_DATA_LF: begin
            if (char_in == CHAR_LF) state_in = ST_LINE_END;
         end
         ST_LINE_END: begin
            if (char_in == CHAR_PLUS) state_in = ST_PLUS;
            else if (char_in == CHAR_CR) state_in = ST_TAIL_LF;
         end
         ST_TAIL_LF: begin
            if (char_in == CHAR_LF) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (char_in == CHAR_E) state_in = ST_ERR_R1;
            else if (char_in == CHAR_O) state_in = ST_OK_K;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // per-state actions and status
   always_comb begin
      status    = STAT_NOT_READY;
      clear_rec = 1'b0;
      store_req = 1'b0;
      close_req = 1'b0;
      ok_load   = 1'b0;
      ok_val    = 1'b0;
      case (state_ff)
         ST_WAIT_CR: begin
            clear_rec = 1'b1;
         end
         ST_WAIT_LF: begin
            clear_rec = 1'b1;
            if (char_in != CHAR_LF) status = STAT_ERROR;
         end
         ST_LINE_START: begin
            if (char_in == CHAR_O || char_in == CHAR_E || char_in == CHAR_PLUS) begin
               status = STAT_NOT_READY;
            end else if (char_in != CHAR_C && is_print(char_in)) begin
               store_req = 1'b1;
            end else begin
               status = STAT_ERROR;
            end
         end
         ST_OK_K: begin
            if (char_in != CHAR_K) status = STAT_ERROR;
         end
         ST_OK_CR, ST_ERR_CR: begin
            if (char_in != CHAR_CR) status = STAT_ERROR;
         end
         ST_OK_LF, ST_ERR_LF, ST_DATA_LF, ST_TAIL_LF: begin
            if (char_in != CHAR_LF) status = STAT_ERROR;
         end
         ST_OK_DONE: begin
            ok_load = 1'b1;
            ok_val  = 1'b1;
            status  = STAT_DONE;
         end
         ST_ERR_DONE: begin
            ok_load = 1'b1;
            status  = STAT_DONE;
         end
         ST_ERR_R1, ST_ERR_R2, ST_ERR_R3: begin
            if (char_in != CHAR_R) status = STAT_ERROR;
         end
         ST_ERR_O: begin
            if (char_in != CHAR_O) status = STAT_ERROR;
         end
         ST_PLUS: begin
            if (char_in == CHAR_C) store_req = 1'b1;
            else status = STAT_ERROR;
         end
         ST_DATA: begin
            if (is_print(char_in)) store_req = 1'b1;
            else if (char_in != CHAR_CR) status = STAT_ERROR;
         end
         ST_LINE_END: begin
            // the close runs even when the byte itself is a syntax error
            close_req = 1'b1;
            if (char_in != CHAR_PLUS && char_in != CHAR_CR) status = STAT_ERROR;
         end
         ST_FINAL: begin
            if (char_in != CHAR_E && char_in != CHAR_O) status = STAT_ERROR;
         end
         default: begin
            status = STAT_ERROR;
         end
      endcase
   end

   assign do_store = store_req && (column_ff < CW'(MAX_LINE_LEN))
                     && (lines_ff < LW'(MAX_LINES));
   assign do_close = close_req && (lines_ff < LW'(MAX_LINES));

   always_comb begin
      lines_in  = lines_ff;
      column_in = column_ff;
      ok_in     = ok_ff;
      if (clear_rec) begin
         lines_in = '0;
         ok_in    = 1'b0;
      end
      if (ok_load) ok_in = ok_val;
      if (do_close) begin
         lines_in  = lines_ff + LW'(1);
         column_in = '0;
      end else if (do_store) begin
         column_in = column_ff + CW'(1);
      end
   end

   always_comb begin
      result.status        = status;
      result.response_ok   = ok_in;
      result.lines_held    = 4'(lines_in);
      result.clear_record  = clear_rec;
      result.char_stored   = do_store;
      result.store_line    = do_store ? 3'(lines_ff) : 3'd0;
      result.store_column  = do_store ? 7'(column_ff) : 7'd0;
      result.store_char    = do_store ? char_in : 8'd0;
      result.line_closed   = do_close;
      result.closed_length = do_close ? 8'(column_ff) : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_WAIT_CR;
         column_ff <= '0;
         lines_ff  <= '0;
         ok_ff     <= 1'b0;
      end else if (step_en) begin
         if (status != STAT_ERROR) state_ff <= state_in;
         column_ff <= column_in;
         lines_ff  <= lines_in;
         ok_ff     <= ok_in;
      end
   end

`ifndef SYNTHESIS
   a_lines_bound: assert property (@(posedge clock) disable iff (reset)
      lines_ff <= LW'(MAX_LINES))
      else $error("line count above its limit");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= CW'(MAX_LINE_LEN))
      else $error("column count above its limit");

   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      step_en && (state_ff == ST_WAIT_CR || state_ff == ST_WAIT_LF)
      |=> lines_ff == '0 && !ok_ff)
      else $error("record not cleared while waiting for frame start");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && status == STAT_ERROR |=> $stable(state_ff))
      else $error("state moved on a syntax error");
`endif

endmodule

### rtl/at_response_parser_top.sv
// AT command response parser: input register, recognizer step and result register
// One byte is taken per transfer and gives exactly one result. A byte sits in the
// input register while the recognizer step runs, then its result is held in the
// output register until taken, so a new byte can be accepted every cycle while
// the result side keeps up; the combinational recognizer step between the two
// registers sets that rate. Results carry status, ok flag, line count and write
// or close events for an external line buffer.
`timescale 1ns / 1ps

module at_response_parser_top
   import atrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   atrp_req_if.sink      req,
   atrp_rsp_if.source    rsp
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       out_valid_ff, out_valid_in;
   result_type rsp_ff;
   result_type step_result;
   logic       advance;
   logic       req_xfer;

   // byte moves to the result register when that register is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign req_xfer    = req.valid && req.ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   atrp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .char_in (char_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) char_ff <= req.char_in;
      if (advance) rsp_ff <= step_result;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.status        = rsp_ff.status;
   assign rsp.response_ok   = rsp_ff.response_ok;
   assign rsp.lines_held    = rsp_ff.lines_held;
   assign rsp.clear_record  = rsp_ff.clear_record;
   assign rsp.char_stored   = rsp_ff.char_stored;
   assign rsp.store_line    = rsp_ff.store_line;
   assign rsp.store_column  = rsp_ff.store_column;
   assign rsp.store_char    = rsp_ff.store_char;
   assign rsp.line_closed   = rsp_ff.line_closed;
   assign rsp.closed_length = rsp_ff.closed_length;

`ifndef SYNTHESIS
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after a step");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(char_ff))
      else $error("pending byte lost while result side stalled");

   a_xfer_loads: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted byte not held in the input register");
`endif

endmodule

### dv/at_response_parser_checker.sv
// checker for the response parser: predicts each result from the accepted bytes and compares
`timescale 1ns / 1ps

module at_response_parser_checker
   import atrp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   atrp_req_if  req,
   atrp_rsp_if  rsp,
   output int   failures,
   output int   pending
);

   state_type  parse_st;
   logic [7:0] col_cnt;
   logic [3:0] line_cnt;
   logic       ok_bit;

   result_type parser_results[$];

   // byte goes to the line buffer only while the line and the buffer have room
   function automatic void buffer_write(input logic [7:0] c, inout result_type r);
      if (int'(col_cnt) < MAX_LINE_LEN && int'(line_cnt) < MAX_LINES) begin
         r.char_stored  = 1'b1;
         r.store_line   = line_cnt[2:0];
         r.store_column = col_cnt[6:0];
         r.store_char   = c;
         col_cnt        = col_cnt + 8'd1;
      end
   endfunction

   function automatic result_type next_parser_result(input logic [7:0] c);
      result_type r;
      state_type  nxt;
      logic       bad_byte;
      logic       printable;
      r         = '0;
      r.status  = STAT_NOT_READY;
      nxt       = parse_st;
      bad_byte  = 1'b0;
      printable = (c >= PRINT_LO) && (c <= PRINT_HI);
      case (parse_st)
         ST_WAIT_CR: begin
            ok_bit         = 1'b0;
            line_cnt       = '0;
            r.clear_record = 1'b1;
            if (c == CHAR_CR) nxt = ST_WAIT_LF;
         end
         ST_WAIT_LF: begin
            // record clear happens even when the byte is rejected
            ok_bit         = 1'b0;
            line_cnt       = '0;
            r.clear_record = 1'b1;
            if (c == CHAR_LF) nxt = ST_LINE_START; else bad_byte = 1'b1;
         end
         ST_LINE_START: begin
            if (c == CHAR_O) nxt = ST_OK_K;
            else if (c == CHAR_E) nxt = ST_ERR_R1;
            else if (c == CHAR_PLUS) nxt = ST_PLUS;
            else if (c != CHAR_C && printable) begin
               buffer_write(c, r);
               nxt = ST_DATA;
            end else bad_byte = 1'b1;
         end
         ST_OK_K:   if (c == CHAR_K) nxt = ST_OK_CR; else bad_byte = 1'b1;
         ST_OK_CR:  if (c == CHAR_CR) nxt = ST_OK_LF; else bad_byte = 1'b1;
         ST_OK_LF:  if (c == CHAR_LF) nxt = ST_OK_DONE; else bad_byte = 1'b1;
         ST_ERR_CR: if (c == CHAR_CR) nxt = ST_ERR_LF; else bad_byte = 1'b1;
         ST_ERR_LF: if (c == CHAR_LF) nxt = ST_ERR_DONE; else bad_byte = 1'b1;
         ST_OK_DONE, ST_ERR_DONE: begin
            ok_bit   = (parse_st == ST_OK_DONE);
            nxt      = (c == CHAR_CR) ? ST_WAIT_LF : ST_WAIT_CR;
            r.status = STAT_DONE;
         end
         ST_ERR_R1: if (c == CHAR_R) nxt = ST_ERR_R2; else bad_byte = 1'b1;
         ST_ERR_R2: if (c == CHAR_R) nxt = ST_ERR_O; else bad_byte = 1'b1;
         ST_ERR_O:  if (c == CHAR_O) nxt = ST_ERR_R3; else bad_byte = 1'b1;
         ST_ERR_R3: if (c == CHAR_R) nxt = ST_ERR_CR; else bad_byte = 1'b1;
         ST_PLUS: begin
            if (c == CHAR_C) begin
               buffer_write(c, r);
               nxt = ST_DATA;
            end else bad_byte = 1'b1;
         end
         ST_DATA: begin
            if (printable) buffer_write(c, r);
            else if (c == CHAR_CR) nxt = ST_DATA_LF;
            else bad_byte = 1'b1;
         end
         ST_DATA_LF: if (c == CHAR_LF) nxt = ST_LINE_END; else bad_byte = 1'b1;
         ST_LINE_END: begin
            // line commit runs before the byte is looked at, so a bad byte closes again
            if (int'(line_cnt) < MAX_LINES) begin
               r.line_closed   = 1'b1;
               r.closed_length = col_cnt;
               line_cnt        = line_cnt + 4'd1;
               col_cnt         = '0;
            end
            if (c == CHAR_PLUS) nxt = ST_PLUS;
            else if (c == CHAR_CR) nxt = ST_TAIL_LF;
            else bad_byte = 1'b1;
         end
         ST_TAIL_LF: if (c == CHAR_LF) nxt = ST_FINAL; else bad_byte = 1'b1;
         ST_FINAL: begin
            if (c == CHAR_E) nxt = ST_ERR_R1;
            else if (c == CHAR_O) nxt = ST_OK_K;
            else bad_byte = 1'b1;
         end
         default: bad_byte = 1'b1;
      endcase
      if (bad_byte) r.status = STAT_ERROR;
      else parse_st = nxt;
      r.response_ok = ok_bit;
      r.lines_held  = line_cnt;
      return r;
   endfunction

   function automatic int check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : compare_results
      result_type want;
      int         bad;
      if (reset) begin
         parse_st = ST_WAIT_CR;
         col_cnt  = '0;
         line_cnt = '0;
         ok_bit   = 1'b0;
         parser_results.delete();
         failures <= 0;
      end else begin
         if (req.valid && req.ready) parser_results.push_back(next_parser_result(req.char_in));
         if (rsp.valid && rsp.ready) begin
            if (parser_results.size() == 0) begin
               $error("result transfer with no byte outstanding");
               bad = 1;
            end else begin
               want = parser_results.pop_front();
               bad  = check_field("status", want.status, rsp.status)
                    + check_field("response_ok", want.response_ok, rsp.response_ok)
                    + check_field("lines_held", want.lines_held, rsp.lines_held)
                    + check_field("clear_record", want.clear_record, rsp.clear_record)
                    + check_field("char_stored", want.char_stored, rsp.char_stored)
                    + check_field("store_line", want.store_line, rsp.store_line)
                    + check_field("store_column", want.store_column, rsp.store_column)
                    + check_field("store_char", want.store_char, rsp.store_char)
                    + check_field("line_closed", want.line_closed, rsp.line_closed)
                    + check_field("closed_length", want.closed_length, rsp.closed_length);
            end
            failures <= failures + bad;
         end
      end
      pending <= parser_results.size();
   end

endmodule

### dv/at_response_parser_top_tb.sv
// testbench top for the response parser: byte stimulus, result stalls and verdict
`timescale 1ns / 1ps

module at_response_parser_top_tb;
   import atrp_pkg::*;

   localparam int RANDOM_BYTES = 650;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   pending;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   bytes_sent = 0;
   int   rcv_mode = 0;
   int   rcv_count = 0;

   // reset clears, rejected byte where LF is due, extreme printables, repeated close after LF, OK and ERROR
   logic [7:0] opening_bytes[$] = '{
      8'h00, 8'hFF, CHAR_CR, 8'h80, CHAR_LF,
      8'h20, 8'h7E, 8'h7F, CHAR_CR, CHAR_LF, 8'hFF, 8'h00,
      CHAR_CR, CHAR_LF, CHAR_O, CHAR_K, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF,
      CHAR_E, CHAR_R, CHAR_R, CHAR_O, CHAR_R, CHAR_CR, CHAR_LF, 8'h41
   };

   atrp_req_if req_bus ();
   atrp_rsp_if rsp_bus ();

   at_response_parser_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   at_response_parser_checker i_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .failures (failures),
      .pending  (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("at_response_parser_top: mismatch");
         $finish;
      end
   end

   // receiver switches between always ready, light stalls and long stalls
   always @(posedge clock) begin
      if (rcv_count == 0) begin
         rcv_mode  <= $urandom_range(0, 2);
         rcv_count <= $urandom_range(20, 80);
      end else begin
         rcv_count <= rcv_count - 1;
      end
      case (rcv_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid   <= 1'b1;
      req_bus.char_in <= c;
      do @(posedge clock); while (!req_bus.ready);
      burst_left = burst_left - 1;
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_response(input int n_lines, input bit long_first, input bit ok_end,
                                input bit corrupt);
      logic [7:0] q[$];
      logic [7:0] c;
      int         len;
      int         idx;
      q = '{CHAR_CR, CHAR_LF};
      for (int i = 0; i < n_lines; i++) begin
         if (i == 0 && $urandom_range(0, 1) == 1) begin
            // plain data line: printable start that is not a response keyword
            do c = 8'($urandom_range(PRINT_LO, PRINT_HI));
            while (c == CHAR_O || c == CHAR_E || c == CHAR_PLUS || c == CHAR_C);
            q.push_back(c);
         end else begin
            q.push_back(CHAR_PLUS);
            q.push_back(CHAR_C);
         end
         if (long_first && i == 0) len = $urandom_range(MAX_LINE_LEN, MAX_LINE_LEN + 6);
         else if ($urandom_range(0, 7) == 0) len = $urandom_range(20, 40);
         else len = $urandom_range(0, 12);
         repeat (len) q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
         q.push_back(CHAR_CR);
         q.push_back(CHAR_LF);
      end
      if (n_lines > 0) begin
         q.push_back(CHAR_CR);
         q.push_back(CHAR_LF);
      end
      if (ok_end) begin
         q.push_back(CHAR_O);
         q.push_back(CHAR_K);
      end else begin
         q.push_back(CHAR_E);
         q.push_back(CHAR_R);
         q.push_back(CHAR_R);
         q.push_back(CHAR_O);
         q.push_back(CHAR_R);
      end
      q.push_back(CHAR_CR);
      q.push_back(CHAR_LF);
      if (corrupt) begin
         idx = $urandom_range(0, q.size() - 1);
         if ($urandom_range(0, 1) == 1) q[idx] = 8'($urandom_range(0, 255));
         else while (q.size() > idx + 1) void'(q.pop_back());
      end
      foreach (q[k]) send_byte(q[k]);
   endtask

   initial begin
      int pick;
      int next_drain;
      req_bus.valid   <= 1'b0;
      req_bus.char_in <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_bytes[k]) send_byte(opening_bytes[k]);
      wait_drained();

      // more lines than the buffer holds, the first one longer than a line can store
      send_response(10, 1'b1, 1'b1, 1'b0);

      next_drain = bytes_sent + 100;
      while (bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            send_response(($urandom_range(0, 9) == 0) ? $urandom_range(8, 10)
                                                      : $urandom_range(0, 4),
                          ($urandom_range(0, 24) == 0), 1'($urandom_range(0, 1)),
                          (pick >= 70));
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
         end
         if (bytes_sent >= next_drain) begin
            wait_drained();
            next_drain = bytes_sent + $urandom_range(80, 160);
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("at_response_parser_top: match");
      end else begin
         $display("at_response_parser_top: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/atrp_pkg.sv
rtl/atrp_if.sv
rtl/atrp_core.sv
rtl/at_response_parser_top.sv
dv/at_response_parser_checker.sv
dv/at_response_parser_top_tb.sv
